### design/box_corner_frame_transform_top_defines.svh
// ----------------------------------------------------------------------------
// Box corner frame transform: assertion macros
// Shared assertion forms for the checker of the top level.
// ----------------------------------------------------------------------------
`ifndef BOX_CORNER_FRAME_TRANSFORM_TOP_DEFINES_SVH
`define BOX_CORNER_FRAME_TRANSFORM_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCFT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bcft_pkg.sv
// ----------------------------------------------------------------------------
// Box corner frame transform package
// Widths, register indexes, state codes and fixed-point helpers.
// ----------------------------------------------------------------------------
package bcft_pkg;

  localparam int POS_FRAC_BITS  = 10;
  localparam int QUAT_FRAC_BITS = 14;

  localparam int QW = 16;
  localparam int PW = 32;
  localparam int SW = 20;
  localparam int MW = 35;
  localparam int VW = 62;
  localparam int AW = 64;

  localparam logic [2:0] CFG_MOUNT_QW = 3'd0;
  localparam logic [2:0] CFG_MOUNT_QX = 3'd1;
  localparam logic [2:0] CFG_MOUNT_QY = 3'd2;
  localparam logic [2:0] CFG_MOUNT_QZ = 3'd3;
  localparam logic [2:0] CFG_MOUNT_TX = 3'd4;
  localparam logic [2:0] CFG_MOUNT_TY = 3'd5;
  localparam logic [2:0] CFG_MOUNT_TZ = 3'd6;

  localparam logic [1:0] QI_W = 2'd0;
  localparam logic [1:0] QI_X = 2'd1;
  localparam logic [1:0] QI_Y = 2'd2;
  localparam logic [1:0] QI_Z = 2'd3;

  localparam logic signed [AW-1:0] LIM60 = 64'sh1000_0000_0000_0000;
  localparam logic signed [MW-1:0] MAT_ONE = 35'sd1 <<< (2 * QUAT_FRAC_BITS);
  localparam logic signed [VW-1:0] CORNER_Z = 62'sd2 <<< POS_FRAC_BITS;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_BUILD = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_POST  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic [1:0] a1;
    logic [1:0] b1;
    logic [1:0] a2;
    logic [1:0] b2;
    logic       sub;
    logic       diag;
  } mat_sel_t;

  function automatic mat_sel_t mat_sel(input logic [3:0] el);
    mat_sel_t s;
    case (el)
      4'd0: s = '{QI_Y, QI_Y, QI_Z, QI_Z, 1'b0, 1'b1};
      4'd1: s = '{QI_X, QI_Y, QI_Z, QI_W, 1'b1, 1'b0};
      4'd2: s = '{QI_X, QI_Z, QI_Y, QI_W, 1'b0, 1'b0};
      4'd3: s = '{QI_X, QI_Y, QI_Z, QI_W, 1'b0, 1'b0};
      4'd4: s = '{QI_X, QI_X, QI_Z, QI_Z, 1'b0, 1'b1};
      4'd5: s = '{QI_Y, QI_Z, QI_X, QI_W, 1'b1, 1'b0};
      4'd6: s = '{QI_X, QI_Z, QI_Y, QI_W, 1'b1, 1'b0};
      4'd7: s = '{QI_Y, QI_Z, QI_X, QI_W, 1'b0, 1'b0};
      4'd8: s = '{QI_X, QI_X, QI_Y, QI_Y, 1'b0, 1'b1};
      default: s = '{QI_W, QI_W, QI_W, QI_W, 1'b0, 1'b0};
    endcase
    return s;
  endfunction

  function automatic logic signed [VW-1:0] clamp60(input logic signed [AW-1:0] v);
    logic signed [VW-1:0] r;
    if (v > LIM60) r = LIM60[VW-1:0];
    else if (v < -LIM60) r = VW'(-LIM60);
    else r = v[VW-1:0];
    return r;
  endfunction

  function automatic logic [31:0] finish32(input logic signed [VW-1:0] v);
    logic signed [AW-1:0] e;
    logic signed [AW-1:0] h;
    logic [31:0] r;
    e = {{(AW-VW){v[VW-1]}}, v};
    if (!v[VW-1]) h = (e + 64'sd1) >>> 1;
    else h = -((-e + 64'sd1) >>> 1);
    if (h > 64'sd2147483647) r = 32'h7fff_ffff;
    else if (h < -64'sd2147483648) r = 32'h8000_0000;
    else r = h[31:0];
    return r;
  endfunction

endpackage

### design/box_corner_frame_transform_top.sv
// ----------------------------------------------------------------------------
// Box corner frame transform
// Maps box footprint corners through box, ego and mounting poses.
// ----------------------------------------------------------------------------
// The input channel takes two kinds of item, told apart by in_tuser. A load
// item stores the ego pose and leaves the block ready in the next cycle. A
// box item yields four corner items on the output channel, the fourth with
// out_tlast set.
// A box first builds its three rotation matrices on a shared 16 by 16
// multiplier: each entry takes a first product, then adds or subtracts a
// second. Each corner then runs 27 matrix products on one shared 33 by 31 bit
// multiplier, each as low and high partial products that are rounded and
// accumulated, then translation, hand-off and output. A new item is taken
// only once the fourth corner is in the output register. The user writes the
// mounting pose through the cfg port only while the block is idle; the block
// does not enforce this. Reset loads identity rotations and zero translations
// and empties the output register. A stalled receiver holds the finished corner
// in the output register as the next corner is computed; the block then waits.
// ----------------------------------------------------------------------------
module box_corner_frame_transform_top
  import bcft_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // rot_w, rot_x, rot_y, rot_z, pos_x, pos_y, pos_z, box_width, box_length
  input  logic [199:0] in_tdata,
  // command
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // corner_index, out_x, out_y, out_z, zero fill
  output logic [103:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  state_t state_r, state_nxt;

  logic signed [QW-1:0] ego_q_r [4], ego_q_nxt [4];
  logic signed [PW-1:0] ego_p_r [3], ego_p_nxt [3];
  logic signed [QW-1:0] mnt_q_r [4], mnt_q_nxt [4];
  logic signed [PW-1:0] mnt_t_r [3], mnt_t_nxt [3];
  logic signed [QW-1:0] box_q_r [4], box_q_nxt [4];
  logic signed [PW-1:0] box_t_r [3], box_t_nxt [3];
  logic [SW-1:0] len_r, len_nxt, wid_r, wid_nxt;

  logic signed [MW-1:0] mat_r [27];
  logic                 mat_we;
  logic [4:0]           mat_wi;
  logic signed [MW-1:0] mat_wd;

  logic [1:0] src_r, src_nxt;
  logic [3:0] el_r, el_nxt;
  logic [1:0] phs_r, phs_nxt;
  logic [1:0] stg_r, stg_nxt;
  logic [1:0] row_r, row_nxt;
  logic [1:0] col_r, col_nxt;
  logic [1:0] crn_r, crn_nxt;

  logic signed [31:0]   mt_r, mt_nxt;
  logic [63:0]          plo_r, plo_nxt;
  logic [62:0]          phi_r, phi_nxt;
  logic                 neg_r, neg_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [VW-1:0] vec_r [3], vec_nxt [3];
  logic signed [VW-1:0] res_r [3], res_nxt [3];

  logic         out_valid_r, out_valid_nxt;
  logic [103:0] out_data_r, out_data_nxt;
  logic         out_last_r, out_last_nxt;

  logic signed [QW-1:0] qsel [4];
  mat_sel_t             ms;
  logic signed [31:0]   p2;
  logic signed [32:0]   qsum;
  logic signed [MW-1:0] two_sum;
  logic [4:0]           mi;
  logic [4:0]           r3;
  logic [4:0]           c3;
  logic signed [MW-1:0] mval;
  logic [32:0]          magm;
  logic [VW-2:0]        magv;
  logic [63:0]          prod;
  logic [94:0]          full;
  logic [94:0]          rnd;
  logic [66:0]          rs;
  logic [60:0]          magt;
  logic signed [AW-1:0] term;
  logic signed [AW-1:0] acc_sum;
  logic [1:0]           nk;
  logic signed [VW-1:0] cv [3];
  logic signed [VW-1:0] ext_len, ext_wid;
  logic signed [AW-1:0] t1, t2;
  logic signed [VW-1:0] c1;

  always_comb begin
    case (src_r)
      2'd0:    qsel = box_q_r;
      2'd1:    qsel = ego_q_r;
      default: qsel = mnt_q_r;
    endcase
  end

  assign ms      = mat_sel(el_r);
  assign p2      = qsel[phs_r[0] ? ms.a2 : ms.a1] * qsel[phs_r[0] ? ms.b2 : ms.b1];
  assign qsum    = ms.sub ? ({mt_r[31], mt_r} - {p2[31], p2}) : ({mt_r[31], mt_r} + {p2[31], p2});
  assign two_sum = {qsum[32], qsum, 1'b0};
  assign mat_wi  = {src_r, 3'b000} + {3'b000, src_r} + {1'b0, el_r};
  assign mat_wd  = ms.diag ? (MAT_ONE - two_sum) : two_sum;

  assign r3   = {2'b00, row_r, 1'b0} + {3'b000, row_r};
  assign c3   = {2'b00, col_r, 1'b0} + {3'b000, col_r};
  assign mi   = {stg_r, 3'b000} + {3'b000, stg_r} +
                ((stg_r == 2'd0) ? (r3 + {3'b000, col_r}) : (c3 + {3'b000, row_r}));
  assign mval = mat_r[mi];
  assign magm = mval[MW-1] ? 33'(-mval) : mval[32:0];
  assign magv = vec_r[col_r][VW-1] ? 61'(-vec_r[col_r]) : vec_r[col_r][VW-2:0];
  assign prod = {31'b0, magm} *
                {33'b0, ((phs_r == 2'd0) ? magv[30:0] : {1'b0, magv[60:31]})};

  assign full = {31'b0, plo_r} + {1'b0, phi_r, 31'b0};
  assign rnd  = full + (95'd1 << (2 * QUAT_FRAC_BITS - 1));
  assign rs   = rnd[94:2*QUAT_FRAC_BITS];
  assign magt = (rs > 67'h1000_0000_0000_0000) ? 61'h1000_0000_0000_0000 : rs[60:0];
  assign term = neg_r ? -$signed({3'b000, magt}) : $signed({3'b000, magt});
  assign acc_sum = ((col_r == 2'd0) ? 64'sd0 : acc_r) + term;

  assign nk      = (state_r == ST_EMIT) ? (crn_r + 2'd1) : 2'd0;
  assign ext_len = $signed({42'b0, len_r});
  assign ext_wid = $signed({42'b0, wid_r});
  assign cv[0]   = (nk == 2'd0 || nk == 2'd3) ? ext_len : -ext_len;
  assign cv[1]   = (nk == 2'd0 || nk == 2'd1) ? ext_wid : -ext_wid;
  assign cv[2]   = CORNER_Z;

  always_comb begin
    state_nxt     = state_r;
    ego_q_nxt     = ego_q_r;
    ego_p_nxt     = ego_p_r;
    mnt_q_nxt     = mnt_q_r;
    mnt_t_nxt     = mnt_t_r;
    box_q_nxt     = box_q_r;
    box_t_nxt     = box_t_r;
    len_nxt       = len_r;
    wid_nxt       = wid_r;
    src_nxt       = src_r;
    el_nxt        = el_r;
    phs_nxt       = phs_r;
    stg_nxt       = stg_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    crn_nxt       = crn_r;
    mt_nxt        = mt_r;
    plo_nxt       = plo_r;
    phi_nxt       = phi_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    vec_nxt       = vec_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    mat_we        = 1'b0;
    t1            = '0;
    t2            = '0;
    c1            = '0;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_MOUNT_QW: mnt_q_nxt[0] = cfg_wdata[15:0];
        CFG_MOUNT_QX: mnt_q_nxt[1] = cfg_wdata[15:0];
        CFG_MOUNT_QY: mnt_q_nxt[2] = cfg_wdata[15:0];
        CFG_MOUNT_QZ: mnt_q_nxt[3] = cfg_wdata[15:0];
        CFG_MOUNT_TX: mnt_t_nxt[0] = cfg_wdata;
        CFG_MOUNT_TY: mnt_t_nxt[1] = cfg_wdata;
        CFG_MOUNT_TZ: mnt_t_nxt[2] = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (!in_tuser[0]) begin
            for (int i = 0; i < 4; i++) ego_q_nxt[i] = in_tdata[16*i +: 16];
            for (int i = 0; i < 3; i++) ego_p_nxt[i] = in_tdata[64 + 32*i +: 32];
          end else begin
            for (int i = 0; i < 4; i++) box_q_nxt[i] = in_tdata[16*i +: 16];
            for (int i = 0; i < 3; i++) box_t_nxt[i] = in_tdata[64 + 32*i +: 32];
            wid_nxt   = in_tdata[179:160];
            len_nxt   = in_tdata[199:180];
            src_nxt   = 2'd0;
            el_nxt    = 4'd0;
            phs_nxt   = 2'd0;
            state_nxt = ST_BUILD;
          end
        end
      end
      ST_BUILD: begin
        if (phs_r == 2'd0) begin
          mt_nxt  = p2;
          phs_nxt = 2'd1;
        end else begin
          mat_we  = 1'b1;
          phs_nxt = 2'd0;
          if (el_r == 4'd8) begin
            el_nxt = 4'd0;
            if (src_r == 2'd2) begin
              state_nxt = ST_MUL;
              crn_nxt   = 2'd0;
              stg_nxt   = 2'd0;
              row_nxt   = 2'd0;
              col_nxt   = 2'd0;
              vec_nxt   = cv;
            end else begin
              src_nxt = src_r + 2'd1;
            end
          end else begin
            el_nxt = el_r + 4'd1;
          end
        end
      end
      ST_MUL: begin
        case (phs_r)
          2'd0: begin
            plo_nxt = prod;
            neg_nxt = mval[MW-1] ^ vec_r[col_r][VW-1];
            phs_nxt = 2'd1;
          end
          2'd1: begin
            phi_nxt = prod[62:0];
            phs_nxt = 2'd2;
          end
          default: begin
            phs_nxt = 2'd0;
            acc_nxt = acc_sum;
            if (col_r == 2'd2) begin
              res_nxt[row_r] = clamp60(acc_sum);
              col_nxt        = 2'd0;
              if (row_r == 2'd2) begin
                row_nxt   = 2'd0;
                state_nxt = ST_POST;
              end else begin
                row_nxt = row_r + 2'd1;
              end
            end else begin
              col_nxt = col_r + 2'd1;
            end
          end
        endcase
      end
      ST_POST: begin
        case (stg_r)
          2'd0: begin
            for (int i = 0; i < 3; i++) begin
              t1 = {{2{res_r[i][VW-1]}}, res_r[i]} +
                   $signed({{31{box_t_r[i][PW-1]}}, box_t_r[i], 1'b0});
              c1 = clamp60(t1);
              t2 = {{2{c1[VW-1]}}, c1} -
                   $signed({{31{ego_p_r[i][PW-1]}}, ego_p_r[i], 1'b0});
              vec_nxt[i] = clamp60(t2);
            end
            stg_nxt   = 2'd1;
            state_nxt = ST_MUL;
          end
          2'd1: begin
            for (int i = 0; i < 3; i++) begin
              t2 = {{2{res_r[i][VW-1]}}, res_r[i]} -
                   $signed({{31{mnt_t_r[i][PW-1]}}, mnt_t_r[i], 1'b0});
              vec_nxt[i] = clamp60(t2);
            end
            stg_nxt   = 2'd2;
            state_nxt = ST_MUL;
          end
          default: state_nxt = ST_EMIT;
        endcase
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b0, finish32(res_r[2]), finish32(res_r[1]),
                           finish32(res_r[0]), crn_r};
          out_last_nxt  = (crn_r == 2'd3);
          if (crn_r == 2'd3) begin
            state_nxt = ST_IDLE;
          end else begin
            crn_nxt   = crn_r + 2'd1;
            stg_nxt   = 2'd0;
            row_nxt   = 2'd0;
            col_nxt   = 2'd0;
            vec_nxt   = cv;
            state_nxt = ST_MUL;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ego_q_r     <= '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
      ego_p_r     <= '{32'sd0, 32'sd0, 32'sd0};
      mnt_q_r     <= '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
      mnt_t_r     <= '{32'sd0, 32'sd0, 32'sd0};
      src_r       <= 2'd0;
      el_r        <= 4'd0;
      phs_r       <= 2'd0;
      stg_r       <= 2'd0;
      row_r       <= 2'd0;
      col_r       <= 2'd0;
      crn_r       <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ego_q_r     <= ego_q_nxt;
      ego_p_r     <= ego_p_nxt;
      mnt_q_r     <= mnt_q_nxt;
      mnt_t_r     <= mnt_t_nxt;
      src_r       <= src_nxt;
      el_r        <= el_nxt;
      phs_r       <= phs_nxt;
      stg_r       <= stg_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      crn_r       <= crn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    box_q_r    <= box_q_nxt;
    box_t_r    <= box_t_nxt;
    len_r      <= len_nxt;
    wid_r      <= wid_nxt;
    mt_r       <= mt_nxt;
    plo_r      <= plo_nxt;
    phi_r      <= phi_nxt;
    neg_r      <= neg_nxt;
    acc_r      <= acc_nxt;
    vec_r      <= vec_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    if (mat_we) mat_r[mat_wi] <= mat_wd;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

### design/bcft_checker.sv
// ----------------------------------------------------------------------------
// Box corner frame transform checker
// Port-level assertions on the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "box_corner_frame_transform_top_defines.svh"

module bcft_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [0:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic         out_tlast
);

  `BCFT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "output item dropped while stalled")
  `BCFT_ASSERT_NEXT(a_box_busy, in_tvalid && in_tready && in_tuser[0], !in_tready, "box item did not make the block busy")
  `BCFT_ASSERT_NEXT(a_load_ready, in_tvalid && in_tready && !in_tuser[0], in_tready, "load item made the block busy")
  `BCFT_ASSERT_SAME(a_mid_box, out_tvalid && !out_tlast, !in_tready, "ready in the middle of a box")
  `BCFT_ASSERT_NEXT(a_last_gap, out_tvalid && out_tready && out_tlast, !out_tvalid, "item follows the last corner at once")

endmodule

bind box_corner_frame_transform_top bcft_checker u_bcft_checker (.*);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Box corner frame transform testbench
// Sends ego pose loads and box items with random stalls on both sides and
// predicts the four sensor-frame corners of each box in fixed point. Each
// corner is checked field by field, and the mounting pose is changed between
// phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bcft_pkg::*;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_BOX  = 1'b1;
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 450;
  localparam longint L60 = 64'sh1000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]  idx;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
  } corner_t;

  class corner_scoreboard;
    corner_t pending_q[$];
    longint mount_rot[4];
    longint mount_pos[3];
    longint ego_rot[4];
    longint ego_pos[3];
    int mismatches;
    int boxes;
    int loads;
    int corners;

    function void reset_state();
      foreach (mount_rot[i]) begin
        mount_rot[i] = 0;
        ego_rot[i] = 0;
      end
      foreach (mount_pos[i]) begin
        mount_pos[i] = 0;
        ego_pos[i] = 0;
      end
      mount_rot[0] = 64'sd1 <<< QUAT_FRAC_BITS;
      ego_rot[0] = 64'sd1 <<< QUAT_FRAC_BITS;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      if (idx <= CFG_MOUNT_QZ) mount_rot[idx] = longint'($signed(val[15:0]));
      else if (idx <= CFG_MOUNT_TZ) mount_pos[idx - CFG_MOUNT_TX] = longint'($signed(val));
    endfunction

    function longint limit60(longint v);
      if (v > L60) return L60;
      if (v < -L60) return -L60;
      return v;
    endfunction

    function longint mul_round(longint a, longint b);
      logic [127:0] ua, ub, p;
      logic neg;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? 128'(-a) : 128'(a);
      ub = (b < 0) ? 128'(-b) : 128'(b);
      p = ua * ub;
      p = (p + (128'd1 << (2 * QUAT_FRAC_BITS - 1))) >> (2 * QUAT_FRAC_BITS);
      if (p > 128'(L60)) p = 128'(L60);
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function void rot_matrix(longint q[4], output longint r[9]);
      longint w, x, y, z, one;
      w = q[0]; x = q[1]; y = q[2]; z = q[3];
      one = 64'sd1 <<< (2 * QUAT_FRAC_BITS);
      r[0] = one - 2 * (y * y + z * z);
      r[1] = 2 * (x * y - z * w);
      r[2] = 2 * (x * z + y * w);
      r[3] = 2 * (x * y + z * w);
      r[4] = one - 2 * (x * x + z * z);
      r[5] = 2 * (y * z - x * w);
      r[6] = 2 * (x * z - y * w);
      r[7] = 2 * (y * z + x * w);
      r[8] = one - 2 * (x * x + y * y);
    endfunction

    function void apply_rot(longint r[9], longint v[3], logic tr, output longint o[3]);
      longint acc;
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++)
          acc += mul_round(tr ? r[j * 3 + i] : r[i * 3 + j], v[j]);
        o[i] = limit60(acc);
      end
    endfunction

    function logic [31:0] half_sat(longint v);
      longint h;
      h = (v >= 0) ? (v + 1) / 2 : -((-v + 1) / 2);
      if (h > 64'sd2147483647) h = 64'sd2147483647;
      if (h < -64'sd2147483648) h = -64'sd2147483648;
      return h[31:0];
    endfunction

    function void note_input(logic cmd, logic [199:0] d);
      longint q[4], t[3], rb[9], re[9], rm[9], c[3], a[3], b[3], len, wid;
      corner_t e;
      for (int i = 0; i < 4; i++) q[i] = longint'($signed(d[16 * i +: 16]));
      for (int i = 0; i < 3; i++) t[i] = longint'($signed(d[64 + 32 * i +: 32]));
      if (cmd == CMD_LOAD) begin
        ego_rot = q;
        ego_pos = t;
        loads++;
        return;
      end
      boxes++;
      wid = longint'(d[179:160]);
      len = longint'(d[199:180]);
      rot_matrix(q, rb);
      rot_matrix(ego_rot, re);
      rot_matrix(mount_rot, rm);
      for (int k = 0; k < 4; k++) begin
        c[0] = (k == 0 || k == 3) ? len : -len;
        c[1] = (k < 2) ? wid : -wid;
        c[2] = 64'sd2 <<< POS_FRAC_BITS;
        apply_rot(rb, c, 1'b0, a);
        for (int i = 0; i < 3; i++)
          a[i] = limit60(limit60(a[i] + 2 * t[i]) - 2 * ego_pos[i]);
        apply_rot(re, a, 1'b1, b);
        for (int i = 0; i < 3; i++) b[i] = limit60(b[i] - 2 * mount_pos[i]);
        apply_rot(rm, b, 1'b1, a);
        e.idx = k[1:0];
        e.x = half_sat(a[0]);
        e.y = half_sat(a[1]);
        e.z = half_sat(a[2]);
        e.last = (k == 3);
        pending_q = {pending_q, e};
      end
    endfunction

    function void check_result(logic [103:0] d, logic last);
      corner_t got, e;
      got = '{d[1:0], d[33:2], d[65:34], d[97:66], last};
      corners++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected corner %p", got);
        return;
      end
      e = pending_q.pop_front();
      if (got !== e || d[103:98] !== 6'd0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: corner mismatch expected %p actual %p fill %h", e, got, d[103:98]);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [199:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  corner_scoreboard sb = new();
  logic idle_on = 1'b1;
  logic hold_req = 1'b0;
  int idle_cycles = 0;

  box_corner_frame_transform_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : result_side
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
      if (hold_req && !held) begin
        hold = 700;
        held = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(idle_on && $urandom_range(99) < 10);
      end
    end
  end

  task automatic send_item(logic cmd, logic [199:0] d);
    if (idle_on && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(cmd, d);
  endtask

  function automatic logic [199:0] pack_item(logic [15:0] qw, logic [15:0] qx,
      logic [15:0] qy, logic [15:0] qz, logic [31:0] px, logic [31:0] py,
      logic [31:0] pz, logic [19:0] wid, logic [19:0] len);
    return {len, wid, pz, py, px, qz, qy, qx, qw};
  endfunction

  function automatic logic [15:0] rand_quat();
    if ($urandom_range(9) == 0) return 16'($urandom());
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'sh7fff_ffff - $urandom_range(3);
      default: return 32'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  function automatic logic [199:0] rand_item();
    return pack_item(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                     rand_pos(), rand_pos(), rand_pos(),
                     20'($urandom()), 20'($urandom()));
  endfunction

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      send_item(($urandom_range(99) < 65) ? CMD_BOX : CMD_LOAD, rand_item());
  endtask

  initial begin
    sb.reset_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity poses, zero and full sizes, extreme translations, non-unit rotations.
    send_item(CMD_BOX, pack_item(16'sd16384, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(CMD_BOX, pack_item(16'sd16384, 0, 0, 0, 1024, -2048, 512,
                                 20'hfffff, 20'hfffff));
    send_item(CMD_LOAD, pack_item(-16'sd16384, 0, 0, 0, 32'h8000_0000,
                                  32'h7fff_ffff, 32'h8000_0000, 20'hfffff, 20'hfffff));
    send_item(CMD_BOX, pack_item(16'sd16384, 0, 0, 0, 32'h7fff_ffff,
                                 32'h8000_0000, 32'h7fff_ffff, 20'hfffff, 0));
    send_item(CMD_LOAD, pack_item(0, 16'sd16384, 0, 0, 0, 0, 0, 0, 0));
    send_item(CMD_BOX, pack_item(0, 0, 16'sd16384, 0, 4096, 4096, 0, 2048, 4096));
    send_item(CMD_BOX, pack_item(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
                                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                 20'hfffff, 20'hfffff));
    send_item(CMD_BOX, pack_item(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, -1, -1, -1,
                                 1, 20'hfffff));
    send_item(CMD_LOAD, pack_item(16'sd11585, 0, 0, 16'sd11585, 100, 200, 300, 5, 5));
    send_item(CMD_BOX, pack_item(16'sd11585, 0, 0, -16'sd11585, 0, 0, 0, 1000, 3000));
    send_item(CMD_LOAD, pack_item(16'sd16384, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();

    write_cfg(CFG_MOUNT_QW, 32'h0000_c000);
    write_cfg(CFG_MOUNT_QX, 32'h0000_4000);
    write_cfg(CFG_MOUNT_QY, 32'h0000_c000);
    write_cfg(CFG_MOUNT_QZ, 32'h0000_4000);
    write_cfg(CFG_MOUNT_TX, 32'h7fff_ffff);
    write_cfg(CFG_MOUNT_TY, 32'h8000_0000);
    write_cfg(CFG_MOUNT_TZ, 32'h7fff_ffff);
    write_cfg(CFG_UNUSED, 32'hffff_ffff);
    send_item(CMD_BOX, pack_item(16'sd16384, 0, 0, 0, 0, 0, 0, 20'hfffff, 20'hfffff));
    send_item(CMD_BOX, rand_item());
    idle_on <= 1'b0;
    random_phase(30);
    idle_on <= 1'b1;
    hold_req <= 1'b1;
    random_phase(6);
    hold_req <= 1'b0;
    wait_drained();

    write_cfg(CFG_MOUNT_QW, 32'h0000_2d41);
    write_cfg(CFG_MOUNT_QX, 32'h0000_0000);
    write_cfg(CFG_MOUNT_QY, 32'h0000_0000);
    write_cfg(CFG_MOUNT_QZ, 32'h0000_2d41);
    write_cfg(CFG_MOUNT_TX, 32'd1536);
    write_cfg(CFG_MOUNT_TY, -32'sd512);
    write_cfg(CFG_MOUNT_TZ, 32'd1843);
    random_phase(40);
    wait_drained();

    for (int i = 0; i < 4; i++) write_cfg(3'(CFG_MOUNT_QW + i), {16'h0, rand_quat()});
    for (int i = 0; i < 3; i++) write_cfg(3'(CFG_MOUNT_TX + i), rand_pos());
    random_phase(40);
    wait_drained();

    $display("Covered %0d box items and %0d pose loads, %0d corners checked,",
             sb.boxes, sb.loads, sb.corners);
    $display("across four mounting poses including the extremes; %0d mismatches.",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/bcft_pkg.sv
design/box_corner_frame_transform_top.sv
design/bcft_checker.sv
tb/testbench.sv
